>>> hdl/binary_to_ascii_digits_defines.svh
// Assertion macros shared by the binary_to_ascii_digits RTL.
// Standalone header; the assertion bodies drop out when SYNTH is defined.
`ifndef BINARY_TO_ASCII_DIGITS_DEFINES_SVH
`define BINARY_TO_ASCII_DIGITS_DEFINES_SVH

`ifndef SYNTH
// Implication or plain property, checked on every rising edge outside reset.
`define BTA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define BTA_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BTA_ASSERT(label, clk, rst_n, prop, msg)
`define BTA_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> hdl/bta_pkg.sv
// Shared types and constants for the binary_to_ascii_digits block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

    localparam int BASE_W     = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;

    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_we;
        logic load;
        logic div_step;
        logic store;
        logic rd_start;
        logic rd_dec;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bit_last;
        logic quo_zero;
        logic cnt_full;
        logic rd_zero;
        logic out_free;
    } sts_t;

    // Saturate the programmed radix to the supported range.
    function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    // ASCII glyph of one digit: '0'-'9' then 'A'-'F'.
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT)
            c = ASCII_ZERO + {3'd0, d};
        else
            c = ASCII_A + {3'd0, d - DEC_LIMIT};
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bta_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bta_ctrl.sv
// Sequencing state machine for binary_to_ascii_digits.
// Depends on bta_pkg and binary_to_ascii_digits_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_ascii_digits_defines.svh"

module bta_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire bta_pkg::sts_t sts,
    output bta_pkg::cmd_t      cmd
);

    bta_pkg::state_t state_reg;
    bta_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bta_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            bta_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cfg_ready  = 1'b1;
                cmd.cfg_we = cfg_valid;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bta_pkg::ST_DIV;
                end
            end
            bta_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.bit_last)
                    state_next = bta_pkg::ST_STORE;
            end
            bta_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.quo_zero || sts.cnt_full)
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = bta_pkg::ST_READ;
                end
                else
                begin
                    state_next = bta_pkg::ST_DIV;
                end
            end
            bta_pkg::ST_READ:
            begin
                state_next = bta_pkg::ST_OUT;
            end
            bta_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.rd_zero)
                    begin
                        state_next = bta_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_dec = 1'b1;
                        state_next = bta_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = bta_pkg::ST_IDLE;
            end
        endcase
    end

    `BTA_ASSERT(a_accept_starts_div, clk, rst_n, (in_valid && !in_stall) |=> (state_reg == bta_pkg::ST_DIV), "accepted item did not start division")
    `BTA_ASSERT(a_div_end_stores, clk, rst_n, (state_reg == bta_pkg::ST_DIV && sts.bit_last) |=> (state_reg == bta_pkg::ST_STORE), "division end did not store")
    `BTA_NEVER(a_cfg_only_idle, clk, rst_n, cmd.cfg_we && (cmd.div_step || cmd.store || cmd.out_load), "config write while busy")

endmodule

`default_nettype wire

>>> hdl/bta_dp.sv
// Datapath for binary_to_ascii_digits: radix register, serial divider,
// digit buffer and output register. Depends on bta_pkg, bta_ram and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_ascii_digits_defines.svh"

module bta_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bta_pkg::BASE_W-1:0]    cfg_data,
    input  wire logic [VALUE_WIDTH-1:0]        value,
    input  wire bta_pkg::cmd_t                 cmd,
    output bta_pkg::sts_t                      sts,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic      [bta_pkg::CHAR_W-1:0]    digit_char,
    output logic                               last_digit
);

    localparam int BIT_CW = $clog2(VALUE_WIDTH);
    localparam int DIG_AW = $clog2(MAX_DIGITS);

    logic [bta_pkg::BASE_W-1:0]  base_cfg_reg;
    logic [bta_pkg::BASE_W-1:0]  base_reg;
    logic [VALUE_WIDTH-1:0]      quo_reg;
    logic [bta_pkg::DIGIT_W-1:0] rem_reg;
    logic [BIT_CW-1:0]           bit_cnt_reg;
    logic [DIG_AW-1:0]           cnt_reg;
    logic [DIG_AW-1:0]           rd_idx_reg;
    logic                        out_valid_reg;
    logic [bta_pkg::CHAR_W-1:0]  digit_char_reg;
    logic                        last_reg;

    logic [bta_pkg::BASE_W-1:0]  trial;
    logic                        ge;
    logic [bta_pkg::BASE_W-1:0]  diff;
    logic [bta_pkg::DIGIT_W-1:0] ram_rdata;

    // One restoring step: shift the next dividend bit into the remainder.
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge    = (trial >= base_reg);
    assign diff  = trial - base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg  <= bta_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
                base_cfg_reg <= cfg_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg    <= bta_pkg::sat_base(base_cfg_reg);
            quo_reg     <= value;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_reg     <= ge ? diff[bta_pkg::DIGIT_W-1:0] : trial[bta_pkg::DIGIT_W-1:0];
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        if (cmd.store)
        begin
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            if (!cmd.rd_start)
                cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.rd_start)
            rd_idx_reg <= cnt_reg;
        else if (cmd.rd_dec)
            rd_idx_reg <= rd_idx_reg - 1'b1;
        if (cmd.out_load)
        begin
            digit_char_reg <= bta_pkg::glyph(ram_rdata);
            last_reg       <= (rd_idx_reg == '0);
        end
    end

    bta_ram #(
        .WIDTH(bta_pkg::DIGIT_W),
        .DEPTH(MAX_DIGITS)
    ) u_digit_buf (
        .clk  (clk),
        .we   (cmd.store),
        .waddr(cnt_reg),
        .wdata(rem_reg),
        .raddr(rd_idx_reg),
        .rdata(ram_rdata)
    );

    assign sts.bit_last = (bit_cnt_reg == BIT_CW'(VALUE_WIDTH - 1));
    assign sts.quo_zero = (quo_reg == '0);
    assign sts.cnt_full = (cnt_reg == DIG_AW'(MAX_DIGITS - 1));
    assign sts.rd_zero  = (rd_idx_reg == '0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_reg;

    `BTA_ASSERT(a_digit_below_base, clk, rst_n, cmd.store |-> ({1'b0, rem_reg} < base_reg), "stored digit not below base")
    `BTA_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid_reg && out_stall, "output overwritten while stalled")
    `BTA_ASSERT(a_load_shows, clk, rst_n, cmd.out_load |=> out_valid_reg, "loaded digit not presented")

endmodule

`default_nettype wire

>>> hdl/binary_to_ascii_digits.sv
// Top level of binary_to_ascii_digits: radix conversion of an unsigned value
// to ASCII digits. Depends on bta_pkg, bta_ctrl and bta_dp.
//
// Usage:
// The input channel (in_valid, in_stall, value) takes one unsigned number per
// item. The output channel (out_valid, out_stall, digit_char, last_digit)
// returns its digits in the programmed base, most significant first, as ASCII
// '0'-'9' and 'A'-'F'; last_digit marks the least significant digit. Zero gives
// the single digit '0'.
// The config channel (cfg_valid, cfg_ready, digit_base) sets the radix; values
// outside 2..16 are saturated when an item starts. Write it only while idle.
// Timing: a shift-subtract divider retires one quotient bit per cycle; each
// remainder it leaves is stored as a digit in the digit buffer, and the digits
// are then read from the buffer into the output register one at a time. One
// item is converted at a time; in_stall is high from acceptance until the
// last digit is loaded into the output register. When the receiver stalls,
// the output register holds its digit and the sequencer waits. Reset
// empties the output and sets the base to 10.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_ascii_digits #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bta_pkg::BASE_W-1:0] digit_base,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [VALUE_WIDTH-1:0]     value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [bta_pkg::CHAR_W-1:0] digit_char,
    output logic                            last_digit
);

    // Commands and status between the sequencer and the datapath.
    bta_pkg::cmd_t cmd;
    bta_pkg::sts_t sts;

    bta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bta_dp #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_data  (digit_base),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .digit_char(digit_char),
        .last_digit(last_digit)
    );

endmodule

`default_nettype wire

>>> dv/tb_binary_to_ascii_digits.sv
// Self-checking testbench for binary_to_ascii_digits: every number sent in is
// converted to its expected ASCII digit run and compared against the output.
// Depends on bta_pkg and the binary_to_ascii_digits RTL; reads no files.
`timescale 1ns / 1ps

module tb_binary_to_ascii_digits;

    // Cycles with no handshake of any kind before the run is declared hung.
    // A base-2 all-ones word spends the longest time dividing before its
    // first digit appears, and this limit leaves several times that margin.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 60;

    // One expected output item: the ASCII code and the end-of-number mark.
    typedef struct packed {
        logic [bta_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } ascii_digit_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // Keeps a private copy of the base register, turns each accepted number
    // into its digit run and checks the output items against it in order.
    class digit_run_tracker;
        logic [bta_pkg::BASE_W-1:0] base_reg;
        ascii_digit_t               pending_digits[$];
        int                         errors;
        string                      glyph_set;

        function new();
            base_reg  = bta_pkg::BASE_RESET;
            errors    = 0;
            glyph_set = "0123456789ABCDEF";
        endfunction

        function void set_base(logic [bta_pkg::BASE_W-1:0] b);
            base_reg = b;
        endfunction

        // The register keeps all five bits; only the radix in use saturates.
        function int unsigned radix();
            int unsigned r;
            r = 32'(base_reg);
            if (r < 32'(bta_pkg::BASE_MIN)) r = 32'(bta_pkg::BASE_MIN);
            if (r > 32'(bta_pkg::BASE_MAX)) r = 32'(bta_pkg::BASE_MAX);
            return r;
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        function void predict_digits(logic [31:0] number);
            int unsigned  r;
            logic [31:0]  rest;
            int unsigned  digits[$];
            byte          code;
            ascii_digit_t item;
            r    = radix();
            rest = number;
            // Division yields the least significant digit first, so each new
            // digit goes to the front; zero still produces a single '0'.
            do begin
                digits.push_front(rest % r);
                rest = rest / r;
            end while (rest != 0);
            foreach (digits[i]) begin
                code      = glyph_set[digits[i]];
                item.ch   = code[bta_pkg::CHAR_W-1:0];
                item.last = (i == digits.size() - 1);
                pending_digits.push_back(item);
            end
        endfunction

        function void check_digit(logic [bta_pkg::CHAR_W-1:0] ch, logic last);
            ascii_digit_t want;
            if (pending_digits.size() == 0) begin
                $error("unexpected item: digit_char 0x%02h last_digit %0b", ch, last);
                errors++;
                return;
            end
            want = pending_digits.pop_front();
            if (ch !== want.ch) begin
                $error("digit_char expected 0x%02h ('%c') actual 0x%02h",
                       want.ch, want.ch, ch);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_digit expected %0b actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (pending_digits.size() != 0) begin
                $error("%0d expected digits never arrived", pending_digits.size());
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [bta_pkg::BASE_W-1:0]   digit_base;
    logic                         in_valid;
    logic                         in_stall;
    logic [31:0]                  value;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [bta_pkg::CHAR_W-1:0]   digit_char;
    logic                         last_digit;

    digit_run_tracker    tracker;
    int                  burst_left = 0;
    int                  idle_cycles = 0;
    stall_mode_t         stall_mode = STALL_NONE;
    int                  stall_left = 0;
    int                  stall_tick = 0;

    binary_to_ascii_digits DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .digit_base (digit_base),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    // 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver switches at random between stall patterns: none at all, a
    // fair coin, mostly stalled, and a fixed periodic rhythm.
    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
            stall_left = $urandom_range(16, 256);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
            default:     out_stall <= ((stall_tick % 5) < 3);
        endcase
    end

    // Output items are sampled at the edge that accepts them, so the values
    // seen are the ones that were stable before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_digit(digit_char, last_digit);
    end

    // Hang detector: any accepted item, digit or register write restarts it.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL binary_to_ascii_digits");
        $finish;
    end

    // Offers one number and holds it until the block takes it. Items go out
    // in bursts; at the end of a burst valid drops for a random gap.
    task automatic offer_value(input logic [31:0] number);
        int gap;
        in_valid <= 1'b1;
        value    <= number;
        do @(posedge clk); while (in_stall);
        tracker.predict_digits(number);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 11);
            gap        = $urandom_range(1, 8);
            in_valid  <= 1'b0;
            repeat (gap) @(posedge clk);
        end else begin
            burst_left--;
        end
    endtask

    // Stops sending and waits until every predicted digit has been seen.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // The base may only change while the block is idle, so drain first and
    // give the sequencer time to return to its idle state.
    task automatic program_base(input logic [bta_pkg::BASE_W-1:0] b);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid  <= 1'b1;
        digit_base <= b;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_base(b);
    endtask

    // Mix of uniform words, small numbers, near-all-ones words, values at or one
    // below a radix power (where digit count changes) and top-bit-cleared words.
    function automatic logic [31:0] pick_value(int unsigned r);
        longint unsigned power;
        int              k;
        logic [31:0]     pick;
        case ($urandom_range(0, 5))
            0, 1: pick = $urandom;
            2:    pick = $urandom_range(0, 300);
            3: begin
                power = 1;
                k     = $urandom_range(1, 32);
                while (k > 0 && power * r <= 64'hFFFF_FFFF) begin
                    power = power * r;
                    k--;
                end
                pick = power[31:0] - $urandom_range(0, 1);
            end
            4:    pick = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: pick = $urandom >> $urandom_range(0, 31);
        endcase
        return pick;
    endfunction

    initial
    begin
        tracker    = new();
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        digit_base = bta_pkg::BASE_RESET;
        in_valid   = 1'b0;
        value      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the reset base of ten: zero, the single/two-digit
        // and nine/ten-digit boundaries, and the largest word.
        offer_value(32'd0);
        offer_value(32'd9);
        offer_value(32'd10);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd1000000000);
        offer_value(32'd999999999);

        // Base sixteen exercises every glyph including 'A' to 'F'.
        program_base(5'd16);
        offer_value(32'hFEDC_BA98);
        offer_value(32'h7654_3210);
        offer_value(32'd0);
        offer_value(32'hFFFF_FFFF);

        // A base below two runs as binary: the longest digit runs there are.
        program_base(5'd0);
        offer_value(32'd0);
        offer_value(32'd1);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h8000_0000);

        // All-ones base saturates to sixteen.
        program_base(5'd31);
        offer_value(32'hABCD_EF01);
        program_base(5'd1);
        offer_value(32'd5);
        program_base(5'd17);
        offer_value(32'h10);
        program_base(5'd3);
        offer_value(32'hFFFF_FFFF);

        // Random part: each phase picks any five-bit base, in range or not.
        // Now and then the sender holds off until the output has drained.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_base(bta_pkg::BASE_W'($urandom_range(0, 31)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
                offer_value(pick_value(tracker.radix()));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.report_leftover();
        if (tracker.errors == 0)
            $display("PASS binary_to_ascii_digits");
        else
            $display("FAIL binary_to_ascii_digits");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bta_pkg.sv
hdl/bta_ram.sv
hdl/bta_ctrl.sv
hdl/bta_dp.sv
hdl/binary_to_ascii_digits.sv
dv/tb_binary_to_ascii_digits.sv
